// ----- src/kaes_pkg.sv -----
// Shared types, constants and codes for the keypoint smoother.
package kaes_pkg;

  localparam int MAX_TRACKS_DEF = 32;
  localparam int MAX_KPTS_DEF   = 17;

  localparam logic [15:0] THRESHOLD_RST  = 16'd13107;
  localparam logic [15:0] ALPHA_LOW_RST  = 16'd9830;
  localparam logic [15:0] ALPHA_HIGH_RST = 16'd45875;

  localparam logic [16:0] ONE_Q16   = 17'h10000;
  localparam logic [31:0] ROUND_Q16 = 32'h0000_8000;
  localparam logic [4:0]  DIV_STEPS = 5'd16;
  localparam logic [3:0]  MAC_LAST  = 4'd9;

  typedef enum logic [1:0] {
    ACT_MEASURE = 2'd0,
    ACT_MISS    = 2'd1,
    ACT_ERASE   = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    REG_THRESHOLD  = 2'd0,
    REG_ALPHA_LOW  = 2'd1,
    REG_ALPHA_HIGH = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRACK,
    ST_POINT,
    ST_DIV,
    ST_MAC,
    ST_EMIT,
    ST_MISS
  } state_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_INIT,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [4:0]  track_slot;
    logic [4:0]  kpt_index;
    logic [5:0]  kpt_count;
    logic [15:0] meas_x;
    logic [15:0] meas_y;
    logic [15:0] meas_conf;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  out_track;
    logic [4:0]  out_kpt;
    logic [15:0] smooth_x;
    logic [15:0] smooth_y;
    logic [15:0] out_conf;
    logic        held;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- src/kaes_chan_if.sv -----
// Valid/ready channel carrying one word of a given payload type.
interface kaes_chan_if #(parameter type data_t = logic);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/kaes_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module kaes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/kaes_div.sv -----
// Radix-2 restoring divider: one quotient bit per cycle, numerator below denominator.
module kaes_div import kaes_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] num,
  input  logic [16:0] den,
  output logic [15:0] quot,
  output div_stat_t   stat
);

  logic [16:0] rem;
  logic [15:0] q;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;
  logic [17:0] shifted;
  logic        fits;

  assign shifted = {rem, 1'b0};
  assign fits    = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_STEPS;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, num};
      q   <= '0;
    end else if (busy) begin
      rem <= fits ? 17'(shifted - {1'b0, den}) : shifted[16:0];
      q   <= {q[14:0], fits};
    end
  end

  assign quot      = q;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ----- src/keypoint_adaptive_ema_smoother.sv -----
// Flow: a seed or hold measure reads its track row, then its point, then gives its word;
// out-of-range skips the point read. A blend runs the divider for the alpha ramp, then
// 10 steps of the shared 17x17 multiply-accumulate; no divider at or below the threshold.
// Input is taken only in idle, so one item at a time; a stalled result holds the input.
// Missed: words follow the track and point reads, one per cycle unless the output stalls;
// erase and ignored items stay in idle, an empty-track miss gives no word. Valid flags clear on synchronous reset.
module keypoint_adaptive_ema_smoother import kaes_pkg::*; #(
  parameter int MAX_TRACKS = MAX_TRACKS_DEF,
  parameter int MAX_KPTS   = MAX_KPTS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  kaes_chan_if.sink    item,
  kaes_chan_if.source  result
);

  localparam int TW     = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int KW     = (MAX_KPTS > 1) ? $clog2(MAX_KPTS) : 1;
  localparam int NPTS   = MAX_TRACKS * MAX_KPTS;
  localparam int PW     = (NPTS > 1) ? $clog2(NPTS) : 1;
  localparam int MASK_W = MAX_KPTS;
  localparam int ROW_W  = 6 + 16 + MASK_W;
  localparam logic [5:0] KCNT = 6'(MAX_KPTS);

  state_t state, state_next;

  logic [15:0] thr, al, ah;

  logic [1:0]  act_r;
  logic [4:0]  slot_r, kpt_r;
  logic [5:0]  cnt_r;
  logic [15:0] mx_r, my_r, mc_r;

  logic [MAX_TRACKS-1:0] row_valid;

  logic             in_ready, accept, slot_ok_in;
  logic             trk_re, trk_we;
  logic [ROW_W-1:0] trk_wdata, trk_rdata, row;
  logic [5:0]       row_total;
  logic [15:0]      row_miss, miss_inc;
  logic [MASK_W-1:0] row_mask, new_mask, wmask, mask_r;
  logic [KW-1:0]    kidx, jidx;
  logic             in_range, meas_ok, pvalid, seed, pvalid_r;
  logic [5:0]       n_calc, miss_n, miss_j;
  logic             miss_last;

  logic        pt_re, pt_we;
  logic [5:0]  pt_off;
  logic [PW-1:0] pt_addr;
  logic [31:0] pt_wdata, pt_rdata;

  logic        div_start;
  logic [15:0] div_quot;
  div_stat_t   div_stat;
  logic        blend_div;

  logic [3:0]  step;
  logic [16:0] mul_a, mul_b;
  acc_op_t     acc_op;
  logic [31:0] prod, acc;
  logic [15:0] t_r, alpha, new_x, old_x, old_y;
  logic [16:0] oma;

  logic [15:0] res_x, res_y, res_conf;
  logic        res_held;

  logic        out_valid, out_free, out_load;
  out_item_t   out_data, out_next;

  assign accept     = item.valid && in_ready;
  assign slot_ok_in = 32'(item.data.track_slot) < MAX_TRACKS;
  assign item.ready = in_ready;
  assign out_free   = !out_valid || result.ready;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  // Track row: {keypoint total, miss count, point valid mask}; invalid rows read as zero.
  assign row       = row_valid[TW'(slot_r)] ? trk_rdata : '0;
  assign row_total = row[ROW_W-1 -: 6];
  assign row_miss  = row[MASK_W +: 16];
  assign row_mask  = row[MASK_W-1:0];

  assign kidx     = KW'(kpt_r);
  assign jidx     = KW'(miss_j);
  assign new_mask = (cnt_r != row_total) ? '0 : row_mask;
  assign in_range = ({1'b0, kpt_r} < cnt_r) && ({1'b0, kpt_r} < KCNT);
  assign meas_ok  = (mx_r != 16'd0) && (my_r != 16'd0) && (mc_r != 16'd0);
  assign pvalid   = in_range && new_mask[kidx];
  assign seed     = in_range && meas_ok && !pvalid;
  assign wmask    = seed ? (new_mask | (MASK_W'(1) << kidx)) : new_mask;
  assign n_calc   = (row_total > KCNT) ? KCNT : row_total;
  assign miss_inc = (row_miss == 16'hFFFF) ? row_miss : row_miss + 16'd1;
  assign miss_last = (miss_j + 6'd1) == miss_n;
  assign blend_div = mc_r > thr;

  assign pt_addr = PW'(32'(slot_r) * MAX_KPTS + 32'(pt_off));

  kaes_ram #(.WIDTH(ROW_W), .DEPTH(MAX_TRACKS)) u_track_ram (
    .clk   (clk),
    .we    (trk_we),
    .waddr (TW'(slot_r)),
    .wdata (trk_wdata),
    .re    (trk_re),
    .raddr (TW'(item.data.track_slot)),
    .rdata (trk_rdata)
  );

  kaes_ram #(.WIDTH(32), .DEPTH(NPTS)) u_point_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_addr),
    .wdata (pt_wdata),
    .re    (pt_re),
    .raddr (pt_addr),
    .rdata (pt_rdata)
  );

  kaes_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (16'(mc_r - thr)),
    .den   (ONE_Q16 - {1'b0, thr}),
    .quot  (div_quot),
    .stat  (div_stat)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && slot_ok_in &&
            (item.data.action == ACT_MEASURE || item.data.action == ACT_MISS)) begin
          state_next = ST_TRACK;
        end
      end
      ST_TRACK: begin
        if (act_r == ACT_MEASURE) begin
          state_next = in_range ? ST_POINT : ST_EMIT;
        end else begin
          state_next = (row_total != 6'd0) ? ST_MISS : ST_IDLE;
        end
      end
      ST_POINT: begin
        if (meas_ok && pvalid_r) begin
          state_next = blend_div ? ST_DIV : ST_MAC;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_DIV:  if (div_stat.done) state_next = ST_MAC;
      ST_MAC:  if (step == MAC_LAST) state_next = ST_EMIT;
      ST_EMIT: if (out_free) state_next = ST_IDLE;
      ST_MISS: if (out_free && miss_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready  = 1'b0;
    trk_re    = 1'b0;
    trk_we    = 1'b0;
    trk_wdata = {cnt_r, 16'd0, wmask};
    pt_re     = 1'b0;
    pt_we     = 1'b0;
    pt_off    = {1'b0, kpt_r};
    pt_wdata  = {mx_r, my_r};
    div_start = 1'b0;
    out_load  = 1'b0;
    out_next.out_track = slot_r;
    out_next.out_kpt   = kpt_r;
    out_next.smooth_x  = res_x;
    out_next.smooth_y  = res_y;
    out_next.out_conf  = res_conf;
    out_next.held      = res_held;
    out_next.last      = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        trk_re   = item.valid;
      end
      ST_TRACK: begin
        if (act_r == ACT_MEASURE) begin
          trk_we = 1'b1;
          pt_re  = in_range;
        end else if (row_total != 6'd0) begin
          trk_we    = 1'b1;
          trk_wdata = {row_total, miss_inc, row_mask};
          pt_re     = 1'b1;
          pt_off    = 6'd0;
        end
      end
      ST_POINT: begin
        pt_we     = meas_ok && !pvalid_r;
        div_start = meas_ok && pvalid_r && blend_div;
      end
      ST_DIV: begin
      end
      ST_MAC: begin
        pt_we    = step == MAC_LAST;
        pt_wdata = {new_x, acc[31:16]};
      end
      ST_EMIT: begin
        out_load = out_free;
      end
      ST_MISS: begin
        out_load = out_free;
        pt_re    = out_free && !miss_last;
        pt_off   = miss_j + 6'd1;
        out_next.out_kpt  = miss_j[4:0];
        out_next.smooth_x = mask_r[jidx] ? pt_rdata[31:16] : 16'd0;
        out_next.smooth_y = mask_r[jidx] ? pt_rdata[15:0] : 16'd0;
        out_next.out_conf = 16'd0;
        out_next.held     = mask_r[jidx];
        out_next.last     = miss_last;
      end
      default: begin
      end
    endcase
  end

  // Multiply-accumulate program: alpha ramp, then the x and y blends.
  always_comb begin
    mul_a  = {1'b0, alpha};
    mul_b  = {1'b0, mx_r};
    acc_op = ACC_HOLD;
    case (step)
      4'd0: begin
        mul_a = {1'b0, al};
        mul_b = ONE_Q16 - {1'b0, t_r};
      end
      4'd1: begin
        mul_a  = {1'b0, ah};
        mul_b  = {1'b0, t_r};
        acc_op = ACC_INIT;
      end
      4'd2: acc_op = ACC_ADD;
      4'd5: begin
        mul_a  = oma;
        mul_b  = {1'b0, old_x};
        acc_op = ACC_INIT;
      end
      4'd6: begin
        mul_b  = {1'b0, my_r};
        acc_op = ACC_ADD;
      end
      4'd7: begin
        mul_a  = oma;
        mul_b  = {1'b0, old_y};
        acc_op = ACC_INIT;
      end
      4'd8: acc_op = ACC_ADD;
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      thr       <= THRESHOLD_RST;
      al        <= ALPHA_LOW_RST;
      ah        <= ALPHA_HIGH_RST;
      row_valid <= '0;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESHOLD:  thr <= cfg_data;
          REG_ALPHA_LOW:  al  <= cfg_data;
          REG_ALPHA_HIGH: ah  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state == ST_IDLE && accept && slot_ok_in && item.data.action == ACT_ERASE) begin
        row_valid[TW'(item.data.track_slot)] <= 1'b0;
      end
      if (state == ST_TRACK && act_r == ACT_MEASURE) begin
        row_valid[TW'(slot_r)] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      step <= (state == ST_MAC) ? step + 4'd1 : 4'd0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      act_r  <= item.data.action;
      slot_r <= item.data.track_slot;
      kpt_r  <= item.data.kpt_index;
      cnt_r  <= item.data.kpt_count;
      mx_r   <= item.data.meas_x;
      my_r   <= item.data.meas_y;
      mc_r   <= item.data.meas_conf;
    end
    if (out_load) begin
      out_data <= out_next;
    end
    unique case (state)
      ST_TRACK: begin
        pvalid_r <= pvalid;
        mask_r   <= row_mask;
        miss_n   <= n_calc;
        miss_j   <= 6'd0;
        res_x    <= 16'd0;
        res_y    <= 16'd0;
        res_conf <= 16'd0;
        res_held <= 1'b0;
      end
      ST_POINT: begin
        old_x <= pt_rdata[31:16];
        old_y <= pt_rdata[15:0];
        t_r   <= 16'd0;
        if (meas_ok && !pvalid_r) begin
          res_x    <= mx_r;
          res_y    <= my_r;
          res_conf <= mc_r;
          res_held <= 1'b1;
        end else if (pvalid_r) begin
          // hold the stored point; a blend overwrites it later
          res_x    <= pt_rdata[31:16];
          res_y    <= pt_rdata[15:0];
          res_conf <= 16'd0;
          res_held <= 1'b1;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          t_r <= div_quot;
        end
      end
      ST_MAC: begin
        prod <= 32'(mul_a * mul_b);
        case (acc_op)
          ACC_INIT: acc <= ROUND_Q16 + prod;
          ACC_ADD:  acc <= acc + prod;
          default: begin
          end
        endcase
        if (step == 4'd3) alpha <= acc[31:16];
        if (step == 4'd4) oma <= ONE_Q16 - {1'b0, alpha};
        if (step == 4'd7) new_x <= acc[31:16];
        if (step == MAC_LAST) begin
          res_x    <= new_x;
          res_y    <= acc[31:16];
          res_conf <= mc_r;
          res_held <= 1'b1;
        end
      end
      ST_MISS: begin
        if (out_free && !miss_last) begin
          miss_j <= miss_j + 6'd1;
        end
      end
      default: begin
      end
    endcase
  end

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == ST_DIV)
    else $error("divider finished outside the divide step");

  a_miss_index: assert property (@(posedge clk) disable iff (rst)
    state == ST_MISS |-> (miss_j < miss_n && miss_n <= KCNT))
    else $error("missed-track index beyond keypoint count");

  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_free) |=> (state == ST_IDLE && result.valid))
    else $error("measure word not presented after emit");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> !in_ready)
    else $error("input taken while divider busy");

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the keypoint smoother: random and corner stimulus, scored live.
module tb;
  import kaes_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_TRACKS = MAX_TRACKS_DEF;
  localparam int MAX_KPTS = MAX_KPTS_DEF;
  localparam logic [1:0] ACT_BAD = 2'd3;
  localparam int PHASE_ITEMS = 160;
  localparam int STALL_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;
  localparam int DRAIN_LIMIT = 100000;
  localparam int LIMIT_CYCLES = 500000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  kaes_chan_if #(.data_t(in_item_t)) item_ch ();
  kaes_chan_if #(.data_t(out_item_t)) res_ch ();

  keypoint_adaptive_ema_smoother #(
    .MAX_TRACKS(MAX_TRACKS),
    .MAX_KPTS(MAX_KPTS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item(item_ch.sink),
    .result(res_ch.source)
  );

  // Predictor state
  logic [15:0] thr_reg;
  logic [15:0] alo_reg;
  logic [15:0] ahi_reg;
  logic [15:0] pos_x [MAX_TRACKS * MAX_KPTS];
  logic [15:0] pos_y [MAX_TRACKS * MAX_KPTS];
  logic pos_held [MAX_TRACKS * MAX_KPTS];
  logic [5:0] kpt_total [MAX_TRACKS];
  logic [15:0] miss_run [MAX_TRACKS];

  in_item_t pending_items [$];
  out_item_t want_words [$];
  logic [5:0] track_shape [MAX_TRACKS];

  int send_idle;
  int recv_idle;
  logic recv_hold;
  logic word_taken;
  int mismatches;
  int items_taken;
  int words_seen;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [15:0] alpha_for(logic [15:0] conf);
    longint c;
    longint th;
    longint t;
    longint acc;
    c = conf;
    th = thr_reg;
    t = 0;
    if (c > th) t = ((c - th) * 65536) / (65536 - th);
    acc = longint'(alo_reg) * 65536 + (longint'(ahi_reg) - longint'(alo_reg)) * t + 32768;
    if (acc < 0) acc = 0;
    return acc[31:16];
  endfunction

  function automatic logic [15:0] blend_pos(logic [15:0] a, logic [15:0] m, logic [15:0] old);
    longint am;
    longint mm;
    longint om;
    longint v;
    am = a;
    mm = m;
    om = old;
    v = (am * mm + (65536 - am) * om + 32768) >> 16;
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic void forget_track(int s);
    for (int k = 0; k < MAX_KPTS; k++) pos_held[s * MAX_KPTS + k] = 1'b0;
  endfunction

  function automatic void push_word(int s, int k, logic [15:0] x, logic [15:0] y,
                                    logic [15:0] c, logic h, logic l);
    out_item_t w;
    w.out_track = 5'(s);
    w.out_kpt = 5'(k);
    w.smooth_x = x;
    w.smooth_y = y;
    w.out_conf = c;
    w.held = h;
    w.last = l;
    want_words.insert(want_words.size(), w);
  endfunction

  function automatic void smooth_step(in_item_t w);
    int s;
    int k;
    int i;
    int n;
    logic [15:0] a;
    s = w.track_slot;
    k = w.kpt_index;
    if (s >= MAX_TRACKS) return;
    case (w.action)
      ACT_MEASURE: begin
        if (w.kpt_count != kpt_total[s]) begin
          forget_track(s);
          kpt_total[s] = w.kpt_count;
        end
        miss_run[s] = '0;
        if (k >= kpt_total[s] || k >= MAX_KPTS) begin
          push_word(s, k, '0, '0, '0, 1'b0, 1'b1);
          return;
        end
        i = s * MAX_KPTS + k;
        if (w.meas_conf != 0 && w.meas_x != 0 && w.meas_y != 0) begin
          if (!pos_held[i]) begin
            pos_x[i] = w.meas_x;
            pos_y[i] = w.meas_y;
            pos_held[i] = 1'b1;
          end else begin
            a = alpha_for(w.meas_conf);
            pos_x[i] = blend_pos(a, w.meas_x, pos_x[i]);
            pos_y[i] = blend_pos(a, w.meas_y, pos_y[i]);
          end
          push_word(s, k, pos_x[i], pos_y[i], w.meas_conf, 1'b1, 1'b1);
        end else if (pos_held[i]) begin
          push_word(s, k, pos_x[i], pos_y[i], '0, 1'b1, 1'b1);
        end else begin
          push_word(s, k, '0, '0, '0, 1'b0, 1'b1);
        end
      end
      ACT_MISS: begin
        n = kpt_total[s];
        if (n == 0) return;
        if (n > MAX_KPTS) n = MAX_KPTS;
        if (miss_run[s] != 16'hFFFF) miss_run[s] = miss_run[s] + 1'b1;
        for (int j = 0; j < n; j++) begin
          i = s * MAX_KPTS + j;
          if (pos_held[i]) push_word(s, j, pos_x[i], pos_y[i], '0, 1'b1, j + 1 == n);
          else push_word(s, j, '0, '0, '0, 1'b0, j + 1 == n);
        end
      end
      ACT_ERASE: begin
        forget_track(s);
        kpt_total[s] = '0;
        miss_run[s] = '0;
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("tb: MISMATCH cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic cmp_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  task automatic check_word(out_item_t got);
    out_item_t want;
    words_seen++;
    if (want_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word track %0d kpt %0d",
                                got.out_track, got.out_kpt));
      return;
    end
    want = want_words.pop_front();
    cmp_field("out_track", got.out_track, want.out_track);
    cmp_field("out_kpt", got.out_kpt, want.out_kpt);
    cmp_field("smooth_x", got.smooth_x, want.smooth_x);
    cmp_field("smooth_y", got.smooth_y, want.smooth_y);
    cmp_field("out_conf", got.out_conf, want.out_conf);
    cmp_field("held", got.held, want.held);
    cmp_field("last", got.last, want.last);
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= item_ch.valid && item_ch.ready;
      if (item_ch.valid && item_ch.ready) begin
        items_taken++;
        smooth_step(item_ch.data);
      end
      if (res_ch.valid && res_ch.ready) check_word(res_ch.data);
    end
  end

  // Input driver: hold the word until taken, then advance or idle
  always @(negedge clk) begin
    if (!rst && (!item_ch.valid || word_taken)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle) begin
        item_ch.data <= pending_items.pop_front();
        item_ch.valid <= 1'b1;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) res_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void add_item(logic [1:0] act, int s, int k, int cnt,
                                   int x, int y, int conf);
    in_item_t it;
    it.action = act;
    it.track_slot = 5'(s);
    it.kpt_index = 5'(k);
    it.kpt_count = 6'(cnt);
    it.meas_x = 16'(x);
    it.meas_y = 16'(y);
    it.meas_conf = 16'(conf);
    pending_items.insert(pending_items.size(), it);
  endfunction

  // Mostly consistent per-track keypoint runs, with some noise mixed in
  function automatic in_item_t make_item();
    in_item_t it;
    int pick;
    int lim;
    pick = $urandom_range(99);
    it.track_slot = ($urandom_range(7) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(3));
    if (pick >= 83 && pick < 87) begin
      case ($urandom_range(2))
        0: track_shape[it.track_slot] = 6'(MAX_KPTS);
        1: track_shape[it.track_slot] = 6'($urandom_range(32, 1));
        default: track_shape[it.track_slot] = 6'($urandom_range(63));
      endcase
    end
    it.kpt_count = track_shape[it.track_slot];
    lim = (it.kpt_count < MAX_KPTS) ? it.kpt_count : MAX_KPTS;
    if (lim == 0 || (pick >= 93 && pick < 97)) it.kpt_index = 5'($urandom_range(31));
    else it.kpt_index = 5'($urandom_range(lim - 1));
    it.meas_x = 16'($urandom);
    it.meas_y = 16'($urandom);
    it.meas_conf = ($urandom_range(3) == 0) ? 16'($urandom_range(20000)) : 16'($urandom);
    it.action = ACT_MEASURE;
    if (pick >= 70 && pick < 80) begin
      it.action = ACT_MISS;
    end else if (pick >= 80 && pick < 83) begin
      it.action = ACT_ERASE;
    end else if (pick >= 87 && pick < 93) begin
      case ($urandom_range(2))
        0: it.meas_x = '0;
        1: it.meas_y = '0;
        default: it.meas_conf = '0;
      endcase
    end else if (pick >= 97) begin
      it.action = ACT_BAD;
    end
    return it;
  endfunction

  task automatic fill_phase();
    in_item_t it;
    int n;
    n = 0;
    while (n < PHASE_ITEMS) begin
      it = make_item();
      pending_items.insert(pending_items.size(), it);
      if (it.action != ACT_BAD) n++;
    end
  endtask

  // Wait until every item is sent and every predicted word is back, then let erase/blend work settle
  task automatic drain();
    int spins;
    spins = 0;
    while ((pending_items.size() != 0 || item_ch.valid || want_words.size() != 0) &&
           spins < DRAIN_LIMIT) begin
      @(posedge clk);
      spins++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] thr, logic [15:0] lo, logic [15:0] hi);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_THRESHOLD;
    cfg_data <= thr;
    @(negedge clk);
    cfg_index <= REG_ALPHA_LOW;
    cfg_data <= lo;
    @(negedge clk);
    cfg_index <= REG_ALPHA_HIGH;
    cfg_data <= hi;
    @(negedge clk);
    cfg_we <= 1'b0;
    thr_reg = thr;
    alo_reg = lo;
    ahi_reg = hi;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_THRESHOLD;
    cfg_data = '0;
    item_ch.valid = 1'b0;
    item_ch.data = '0;
    res_ch.ready = 1'b0;
    recv_hold = 1'b0;
    send_idle = 26;
    recv_idle = 51;
    mismatches = 0;
    items_taken = 0;
    words_seen = 0;
    cycle_count = 0;
    thr_reg = THRESHOLD_RST;
    alo_reg = ALPHA_LOW_RST;
    ahi_reg = ALPHA_HIGH_RST;
    for (int i = 0; i < MAX_TRACKS * MAX_KPTS; i++) pos_held[i] = 1'b0;
    for (int s = 0; s < MAX_TRACKS; s++) begin
      kpt_total[s] = '0;
      miss_run[s] = '0;
      track_shape[s] = 6'(MAX_KPTS);
    end
    track_shape[1] = 6'd5;
    track_shape[2] = 6'd32;

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed corners under reset register values
    add_item(ACT_MEASURE, 0, 0, 17, 1, 1, 1);
    add_item(ACT_MEASURE, 0, 0, 17, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_item(ACT_MEASURE, 0, 0, 17, 16'h8000, 16'h1234, THRESHOLD_RST);
    add_item(ACT_MEASURE, 0, 0, 17, 0, 5, 5);
    add_item(ACT_MEASURE, 0, 1, 17, 5, 0, 9);
    add_item(ACT_MEASURE, 0, 2, 17, 7, 7, 0);
    add_item(ACT_MEASURE, 0, 16, 17, 16'hFFFF, 1, 16'h8000);
    add_item(ACT_MEASURE, 0, 17, 17, 100, 100, 100);
    add_item(ACT_MEASURE, 0, 31, 17, 100, 100, 100);
    add_item(ACT_MISS, 0, 0, 17, 0, 0, 0);
    add_item(ACT_MEASURE, 1, 3, 5, 16'h0400, 16'h0300, 16'hC000);
    add_item(ACT_MEASURE, 1, 5, 5, 16'h0400, 16'h0300, 16'hC000);
    add_item(ACT_MISS, 1, 0, 5, 0, 0, 0);
    add_item(ACT_MEASURE, 1, 3, 6, 16'h0800, 16'h0900, 16'h4000);
    add_item(ACT_ERASE, 1, 0, 6, 0, 0, 0);
    add_item(ACT_MISS, 1, 0, 6, 0, 0, 0);
    add_item(ACT_MEASURE, 31, 0, 63, 16'hAAAA, 16'h5555, 16'hFFFF);
    add_item(ACT_MISS, 31, 0, 63, 0, 0, 0);
    add_item(ACT_MEASURE, 31, 0, 0, 16'hAAAA, 16'h5555, 16'hFFFF);
    add_item(ACT_MISS, 31, 0, 0, 0, 0, 0);
    add_item(ACT_BAD, 0, 0, 17, 1, 1, 1);
    add_item(ACT_MISS, 0, 0, 17, 0, 0, 0);
    add_item(ACT_MEASURE, 2, 0, 1, 16'h1000, 16'h2000, 16'h3000);
    add_item(ACT_MEASURE, 2, 0, 1, 16'h2000, 16'h1000, 16'hFFFF);
    drain();

    // Extremes: full ramp from zero alpha to near one, plus a long output stall
    set_regs(16'h0000, 16'h0000, 16'hFFFF);
    fill_phase();
    recv_hold = 1'b1;
    repeat (STALL_CYCLES) @(posedge clk);
    recv_hold = 1'b0;
    drain();

    // Threshold at the top, inverted ramp; swap idle profiles
    set_regs(16'hFFFF, 16'hFFFF, 16'h0000);
    send_idle = 51;
    recv_idle = 26;
    fill_phase();
    drain();

    set_regs(16'($urandom), 16'($urandom), 16'($urandom));
    send_idle = 0;
    recv_idle = 0;
    fill_phase();
    drain();

    if (want_words.size() != 0)
      report_mismatch($sformatf("%0d predicted words never arrived", want_words.size()));
    $display("tb: %0d items taken, %0d result words scored, %0d mismatches",
             items_taken, words_seen, mismatches);
    $display("tb: corners, 4 register settings, 3 idle profiles, one long output stall");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/kaes_pkg.sv
src/kaes_chan_if.sv
src/kaes_ram.sv
src/kaes_div.sv
src/keypoint_adaptive_ema_smoother.sv
sim/tb.sv
